### rtl/core/shqn_pkg.sv
package shqn_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_INTERVAL_STEPS = 2'd0;
    localparam logic [1:0] CFG_FILTER_GAIN    = 2'd1;
    localparam logic [1:0] CFG_FILTER_NORM    = 2'd2;

    // configuration reset values
    localparam logic [3:0]  STEPS_RESET = 4'd1;
    localparam logic [15:0] GAIN_RESET  = 16'd76;
    localparam logic [15:0] NORM_RESET  = 16'd64336;
    localparam logic [3:0]  STEPS_MAX   = 4'd12;
    localparam logic [3:0]  STEPS_MIN   = 4'd1;

    // schmitt thresholds at 12288 lsb per volt
    localparam logic signed [18:0] CLK_HIGH = 19'sd24576;
    localparam logic signed [18:0] CLK_LOW  = 19'sd1228;

    // field widths
    localparam int SAMPLE_W = 19;
    localparam int MEM_W    = 24;
    localparam int MUL_A_W  = 20;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int DIV_STEPS = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_IN,
        ST_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_OUT,
        ST_MUL_FB,
        ST_WB,
        ST_TRIG,
        ST_DIV,
        ST_QUANT,
        ST_DONE
    } state_t;

endpackage

### rtl/core/shqn_ram.sv
module shqn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/sample_hold_quantizer_noise.sv
// a connected item passes the schmitt trigger and the quantizer; a filtered-noise
// item first passes the lowpass filter; an out-of-range bank or channel is answered
// with zeros; an in-range item runs the 9-step remainder loop of the quantizer and,
// if filtered, 4 passes through the shared 20x17 multiplier; one item at a time
// reset: synchronous active-low aresetn clears the sequencer, output valid, filter
// valid bits, triggers, hold registers and config; no clearing pass is needed
module sample_hold_quantizer_noise #(
    parameter int CHANNELS = 16,
    parameter int BANKS    = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_bank,
    input  logic [3:0]          s_channel,
    input  logic                s_connected,
    input  logic signed [18:0]  s_signal_sample,
    input  logic signed [18:0]  s_noise_sample,
    input  logic signed [18:0]  s_clock_sample,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_out_bank,
    output logic [3:0]          m_out_channel,
    output logic signed [18:0]  m_held_value,
    output logic signed [18:0]  m_quantized_value
);
    import shqn_pkg::*;

    localparam int DEPTH = BANKS * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = (BANKS > 1) ? $clog2(BANKS) : 1;

    // configuration registers
    logic [3:0]  steps_reg;
    logic [15:0] gain_reg;
    logic [15:0] norm_reg;

    // sequencer
    state_t state_reg, state_next;
    logic [3:0] cnt_reg;

    // latched transaction
    logic [1:0]              bank_reg;
    logic [3:0]              chan_reg;
    logic signed [18:0]      noise_reg;
    logic signed [18:0]      clk_reg;
    logic [AW-1:0]           addr_reg;

    // datapath
    logic signed [18:0]      v_reg;       // value offered to the hold register
    logic signed [MEM_W-1:0] mem_reg;     // filter memory of this channel
    logic signed [PROD_W-1:0] prod_reg;   // shared multiplier output
    logic signed [PROD_W-1:0] acc_reg;    // low partial product of s * norm
    logic signed [PROD_W-1:0] s_reg;      // in * gain + mem * 4096
    logic [19:0]             rem_reg;
    logic [19:0]             absx_reg;
    logic                    neg_reg;
    logic [21:0]             dsr_reg;     // divisor shifted, starts at q << 8
    logic signed [18:0]      held_res_reg;
    logic signed [18:0]      quant_res_reg;

    // per-bank state and filter valid bits
    logic                    trig_reg [BANKS];
    logic signed [18:0]      hold_reg [BANKS];
    logic [DEPTH-1:0]        fvalid_reg;

    // output register
    logic                    m_valid_reg;
    logic [1:0]              out_bank_reg;
    logic [3:0]              out_chan_reg;
    logic signed [18:0]      out_held_reg;
    logic signed [18:0]      out_quant_reg;

    // combinational
    logic                    accept;
    logic                    in_range;
    logic [7:0]              addr_full;
    logic                    out_load;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                    ram_we;
    logic [MEM_W-1:0]        ram_rdata;
    logic [3:0]              steps_sat;
    logic [BW-1:0]           bidx;
    logic signed [54:0]      total;
    logic signed [18:0]      lp_out;
    logic signed [PROD_W-1:0] fb_round;
    logic signed [25:0]      mem_sum;
    logic signed [MEM_W-1:0] mem_new;
    logic                    rise;
    logic signed [18:0]      held_new;
    logic signed [19:0]      xq;
    logic [19:0]             mag;
    logic signed [19:0]      quant_full;

    assign accept   = s_valid && s_ready;
    assign addr_full = 8'(s_bank) * 8'(CHANNELS) + 8'(s_channel);
    assign in_range = ({30'd0, s_bank} < BANKS) && ({28'd0, s_channel} < CHANNELS);
    assign bidx     = BW'(bank_reg);

    // step count clipped to 1..12
    always_comb begin
        if (steps_reg < STEPS_MIN) begin
            steps_sat = STEPS_MIN;
        end else if (steps_reg > STEPS_MAX) begin
            steps_sat = STEPS_MAX;
        end else begin
            steps_sat = steps_reg;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= STEPS_RESET;
            gain_reg  <= GAIN_RESET;
            norm_reg  <= NORM_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_INTERVAL_STEPS: steps_reg <= cfg_data[3:0];
                CFG_FILTER_GAIN:    gain_reg  <= cfg_data;
                CFG_FILTER_NORM:    norm_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // filter memory, one word per bank and channel
    shqn_ram #(
        .WIDTH(MEM_W),
        .DEPTH(DEPTH)
    ) u_fmem (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (mem_new),
        .re    (accept && in_range),
        .raddr (AW'(addr_full)),
        .rdata (ram_rdata)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state, multiplier operand select and strobes
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!in_range) begin
                        state_next = ST_DONE;
                    end else if (s_connected) begin
                        state_next = ST_TRIG;
                    end else begin
                        state_next = ST_MUL_IN;
                    end
                end
            end
            ST_MUL_IN: begin
                mul_a      = MUL_A_W'(noise_reg);
                mul_b      = {1'b0, gain_reg};
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                mul_a      = {2'b00, s_reg[17:0]};
                mul_b      = {1'b0, norm_reg};
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                mul_a      = {s_reg[PROD_W-1], s_reg[PROD_W-1:18]};
                mul_b      = {1'b0, norm_reg};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                state_next = ST_MUL_FB;
            end
            ST_MUL_FB: begin
                mul_a      = MUL_A_W'(noise_reg) - MUL_A_W'(v_reg);
                mul_b      = {1'b0, gain_reg};
                state_next = ST_WB;
            end
            ST_WB: begin
                ram_we     = 1'b1;
                state_next = ST_TRIG;
            end
            ST_TRIG: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == 4'd0) begin
                    state_next = ST_QUANT;
                end
            end
            ST_QUANT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // s * norm = (s_hi * norm) << 18 + s_lo * norm, rounded half up at bit 28
    assign total = {prod_reg, 18'd0} + {{18{acc_reg[PROD_W-1]}}, acc_reg}
                 + 55'sd134217728;

    // saturate the lowpass output to 19 bits
    always_comb begin
        if (total[54:46] == {9{total[46]}}) begin
            lp_out = total[46:28];
        end else if (total[54]) begin
            lp_out = 19'sh40000;
        end else begin
            lp_out = 19'sh3FFFF;
        end
    end

    // memory update: round((in - out) * gain / 4096) + out, saturated to 24 bits
    assign fb_round = prod_reg + 37'sd2048;
    assign mem_sum  = {fb_round[PROD_W-1], fb_round[PROD_W-1:12]}
                    + 26'(v_reg);

    always_comb begin
        if (mem_sum[25:23] == {3{mem_sum[23]}}) begin
            mem_new = mem_sum[23:0];
        end else if (mem_sum[25]) begin
            mem_new = 24'sh800000;
        end else begin
            mem_new = 24'sh7FFFFF;
        end
    end

    // schmitt trigger edge and quantizer offset
    assign rise     = !trig_reg[bidx] && (clk_reg >= CLK_HIGH);
    assign held_new = rise ? v_reg : hold_reg[bidx];
    assign xq       = 20'(held_new) - {7'd0, steps_sat, 9'd0};

    // trunc(x / q) * q is |x| minus its remainder, with the sign of x
    assign mag        = absx_reg - rem_reg;
    assign quant_full = neg_reg ? -$signed(mag) : $signed(mag);

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            bank_reg  <= s_bank;
            chan_reg  <= s_channel;
            noise_reg <= s_noise_sample;
            clk_reg   <= s_clock_sample;
            addr_reg  <= AW'(addr_full);
            v_reg     <= s_signal_sample;
            if (!in_range) begin
                held_res_reg  <= '0;
                quant_res_reg <= '0;
            end
        end
        if (state_reg == ST_MUL_IN || state_reg == ST_MUL_LO || state_reg == ST_MUL_HI
                || state_reg == ST_MUL_FB) begin
            prod_reg <= mul_a * mul_b;
        end
        unique case (state_reg)
            ST_MUL_IN: begin
                mem_reg <= fvalid_reg[addr_reg] ? ram_rdata : '0;
            end
            ST_SUM: begin
                s_reg <= prod_reg + {mem_reg[MEM_W-1], mem_reg, 12'd0};
            end
            ST_MUL_HI: begin
                acc_reg <= prod_reg;
            end
            ST_OUT: begin
                v_reg <= lp_out;
            end
            ST_TRIG: begin
                held_res_reg <= held_new;
                neg_reg      <= xq[19];
                absx_reg     <= xq[19] ? 20'(-xq) : 20'(xq);
                rem_reg      <= xq[19] ? 20'(-xq) : 20'(xq);
                dsr_reg      <= {steps_sat, 18'd0};
            end
            ST_DIV: begin
                // one restoring step per cycle
                if ({2'b00, rem_reg} >= dsr_reg) begin
                    rem_reg <= rem_reg - dsr_reg[19:0];
                end
                dsr_reg <= dsr_reg >> 1;
            end
            ST_QUANT: begin
                quant_res_reg <= quant_full[18:0];
            end
            default: ;
        endcase
    end

    // step counter of the remainder loop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (state_reg == ST_TRIG) begin
            cnt_reg <= 4'(DIV_STEPS - 1);
        end else if (state_reg == ST_DIV) begin
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    // per-bank trigger and hold, filter valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvalid_reg <= '0;
            for (int i = 0; i < BANKS; i++) begin
                trig_reg[i] <= 1'b0;
                hold_reg[i] <= '0;
            end
        end else begin
            if (ram_we) begin
                fvalid_reg[addr_reg] <= 1'b1;
            end
            if (state_reg == ST_TRIG) begin
                if (trig_reg[bidx]) begin
                    if (clk_reg <= CLK_LOW) begin
                        trig_reg[bidx] <= 1'b0;
                    end
                end else if (rise) begin
                    trig_reg[bidx] <= 1'b1;
                    hold_reg[bidx] <= v_reg;
                end
            end
        end
    end

    // output register: the next transaction may enter while a result waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_bank_reg  <= bank_reg;
            out_chan_reg  <= chan_reg;
            out_held_reg  <= held_res_reg;
            out_quant_reg <= quant_res_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_bank        = out_bank_reg;
    assign m_out_channel     = out_chan_reg;
    assign m_held_value      = out_held_reg;
    assign m_quantized_value = out_quant_reg;

endmodule

### rtl/core/shqn_sva.sv
module shqn_sva #(
    parameter int CHANNELS = 16,
    parameter int BANKS    = 3
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_out_bank,
    input logic [3:0]         m_out_channel,
    input logic signed [18:0] m_held_value,
    input logic signed [18:0] m_quantized_value
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // the block leaves idle once a transaction is taken, so ready drops after one is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held across an accepted transaction");

    // quantized value is a multiple of 1024 lsb
    a_quant_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_quantized_value[9:0] == 10'd0)
        else $error("quantized value off the step grid");

    // out-of-range bank or channel gives zero results
    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ({30'd0, m_out_bank} >= BANKS || {28'd0, m_out_channel} >= CHANNELS)
        |-> m_held_value == 19'sd0 && m_quantized_value == 19'sd0)
        else $error("nonzero result for out-of-range transaction");

    // stalled result holds
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_held_value)
        && $stable(m_quantized_value))
        else $error("stalled result changed");

endmodule

bind sample_hold_quantizer_noise shqn_sva #(
    .CHANNELS(CHANNELS),
    .BANKS(BANKS)
) u_shqn_sva (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_out_bank        (m_out_bank),
    .m_out_channel     (m_out_channel),
    .m_held_value      (m_held_value),
    .m_quantized_value (m_quantized_value)
);

### bench/tb_sample_hold_quantizer_noise.sv
`timescale 1ns / 100ps

module tb_sample_hold_quantizer_noise;

    import shqn_pkg::*;

    localparam int CHANNELS_N     = 16;
    localparam int BANKS_N        = 3;
    localparam int DIR_ROWS       = 23;
    localparam int FIXED_PHASES   = 7;
    localparam int PHASES         = 9;
    localparam int RAND_PER_PHASE = 120;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 40;   // well past the worst latency

    // voltage extremes at 12288 lsb per volt
    localparam logic [18:0] VOLT_MAX = 19'd163839;
    localparam logic [18:0] VOLT_MIN = 19'h58000;   // -163840
    localparam int          VOLT_HI  = 163839;
    localparam int          VOLT_LO  = -163840;

    typedef struct packed {
        logic [1:0]  bank;
        logic [3:0]  channel;
        logic        connected;
        logic [18:0] sig;
        logic [18:0] noise;
        logic [18:0] clk_smp;
    } sample_t;

    typedef struct packed {
        logic [1:0]  bank;
        logic [3:0]  channel;
        logic [18:0] held;
        logic [18:0] quant;
    } result_t;

    // directed row: pinned rows carry a hand-written held and quantized value
    typedef struct packed {
        sample_t     smp;
        logic        pinned;
        logic [18:0] held;
        logic [18:0] quant;
    } dir_row_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // dut inputs, all known from time zero
    logic               cfg_we            = 1'b0;
    logic [1:0]         cfg_index         = CFG_INTERVAL_STEPS;
    logic [15:0]        cfg_data          = 16'd0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic [1:0]         s_bank            = 2'd0;
    logic [3:0]         s_channel         = 4'd0;
    logic               s_connected       = 1'b0;
    logic signed [18:0] s_signal_sample   = '0;
    logic signed [18:0] s_noise_sample    = '0;
    logic signed [18:0] s_clock_sample    = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic [1:0]         m_out_bank;
    logic [3:0]         m_out_channel;
    logic signed [18:0] m_held_value;
    logic signed [18:0] m_quantized_value;

    // travels with the payload so the monitor sees it at the accepting edge
    logic        row_pinned = 1'b0;
    logic [18:0] row_held   = '0;
    logic [18:0] row_quant  = '0;

    sample_hold_quantizer_noise #(
        .CHANNELS(CHANNELS_N),
        .BANKS   (BANKS_N)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_bank           (s_bank),
        .s_channel        (s_channel),
        .s_connected      (s_connected),
        .s_signal_sample  (s_signal_sample),
        .s_noise_sample   (s_noise_sample),
        .s_clock_sample   (s_clock_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_bank       (m_out_bank),
        .m_out_channel    (m_out_channel),
        .m_held_value     (m_held_value),
        .m_quantized_value(m_quantized_value)
    );

    // predictor state: registers, per bank/channel lowpass memory, per bank trigger and hold
    logic [3:0]         steps_cfg;
    logic [15:0]        gain_cfg;
    logic [15:0]        norm_cfg;
    logic signed [23:0] filt_mem [BANKS_N * CHANNELS_N];
    logic               trig_high [BANKS_N];
    logic signed [18:0] hold_reg [BANKS_N];

    result_t held_results [$];   // held/quantized values still to come out

    int fail_count     = 0;
    int sent_count     = 0;
    int results_seen   = 0;
    int filtered_items = 0;
    int offrange_items = 0;
    int latch_events   = 0;
    int settings_count = 1;
    int quiet_cycles   = 0;
    int pace_mode      = 0;   // 0 back to back, 1 short gaps, 2 long gaps
    int stall_mode     = 0;   // 0 always ready, 1 scattered stalls, 2 long stall windows
    int burst_left     = 0;
    int stall_run      = 0;

    // directed opening: reset state, range extremes, trigger thresholds,
    // out-of-range bank, half-step boundaries, connected items leaving the filter alone
    dir_row_t opening_rows [DIR_ROWS] = '{
        // first item after reset: nothing latched yet
        '{'{2'd0, 4'd0, 1'b1, 19'd0, 19'd0, 19'd0}, 1'b1, 19'd0, 19'd0},
        // bank out of range: zeros, no state touched
        '{'{2'd3, 4'd0, 1'b1, 19'd1000, 19'd0, VOLT_MAX}, 1'b1, 19'd0, 19'd0},
        // clock exactly at 2 v latches the positive extreme
        '{'{2'd1, 4'd3, 1'b1, VOLT_MAX, 19'd0, CLK_HIGH}, 1'b1, VOLT_MAX, 19'd162816},
        '{'{2'd1, 4'd4, 1'b1, -19'sd5000, 19'd0, CLK_HIGH - 19'sd1}, 1'b0, 19'd0, 19'd0},
        '{'{2'd1, 4'd4, 1'b1, -19'sd5000, 19'd0, CLK_LOW + 19'sd1}, 1'b0, 19'd0, 19'd0},
        // exactly 0.1 v clears the trigger
        '{'{2'd1, 4'd5, 1'b1, -19'sd5000, 19'd0, CLK_LOW}, 1'b0, 19'd0, 19'd0},
        // rises again on the negative extreme
        '{'{2'd1, 4'd5, 1'b1, VOLT_MIN, 19'd0, CLK_HIGH}, 1'b1, VOLT_MIN, VOLT_MIN},
        // filtered noise with the trigger low: hold stays at reset
        '{'{2'd2, 4'd0, 1'b0, 19'd0, VOLT_MAX, 19'd0}, 1'b1, 19'd0, 19'd0},
        '{'{2'd2, 4'd0, 1'b0, 19'd0, VOLT_MAX, VOLT_MAX}, 1'b0, 19'd0, 19'd0},
        '{'{2'd2, 4'd1, 1'b0, 19'd0, VOLT_MIN, VOLT_MIN}, 1'b0, 19'd0, 19'd0},
        '{'{2'd2, 4'd1, 1'b0, 19'd0, VOLT_MIN, CLK_HIGH}, 1'b0, 19'd0, 19'd0},
        // out of range noise item must not touch any filter memory
        '{'{2'd3, 4'd15, 1'b0, 19'd0, VOLT_MIN, VOLT_MAX}, 1'b1, 19'd0, 19'd0},
        '{'{2'd0, 4'd15, 1'b0, 19'd0, -19'sd1, CLK_HIGH}, 1'b0, 19'd0, 19'd0},
        '{'{2'd0, 4'd15, 1'b1, -19'sd1, 19'd0, CLK_LOW}, 1'b0, 19'd0, 19'd0},
        // half-step boundaries of the quantizer
        '{'{2'd0, 4'd7, 1'b1, 19'd512, 19'd0, CLK_HIGH}, 1'b0, 19'd0, 19'd0},
        '{'{2'd0, 4'd7, 1'b1, 19'd511, 19'd0, 19'd0}, 1'b0, 19'd0, 19'd0},
        '{'{2'd0, 4'd8, 1'b1, 19'd511, 19'd0, 19'd24600}, 1'b0, 19'd0, 19'd0},
        '{'{2'd0, 4'd8, 1'b1, -19'sd513, 19'd0, 19'd0}, 1'b0, 19'd0, 19'd0},
        '{'{2'd0, 4'd8, 1'b1, -19'sd513, 19'd0, CLK_HIGH}, 1'b0, 19'd0, 19'd0},
        // connected item on a channel with filter history, then let it decay
        '{'{2'd2, 4'd0, 1'b1, 19'd7, VOLT_MIN, 19'd0}, 1'b0, 19'd0, 19'd0},
        '{'{2'd2, 4'd0, 1'b0, 19'd0, 19'd0, 19'd0}, 1'b0, 19'd0, 19'd0},
        '{'{2'd2, 4'd0, 1'b0, 19'd0, 19'd0, CLK_HIGH}, 1'b0, 19'd0, 19'd0},
        '{'{2'd1, 4'd15, 1'b0, 19'd0, VOLT_MAX, VOLT_MAX}, 1'b0, 19'd0, 19'd0}
    };

    // fixed register settings, extremes first; later phases draw random ones
    logic [3:0]  phase_steps [FIXED_PHASES] = '{4'd0, 4'd15, 4'd12, 4'd13, 4'd1, 4'd0, 4'd5};
    logic [15:0] phase_gain  [FIXED_PHASES] =
        '{16'd0, 16'hFFFF, 16'd4096, 16'd76, 16'hFFFF, 16'd0, 16'd200};
    logic [15:0] phase_norm  [FIXED_PHASES] =
        '{16'd0, 16'hFFFF, 16'd32768, 16'd64336, 16'd0, 16'hFFFF, 16'd65208};

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // one-pole lowpass on the noise sample, q.12 gain and q0.16 normalizer
    function automatic logic signed [18:0] noise_lowpass(input logic signed [18:0] x,
                                                         input int idx);
        longint xin, g, n, acc, y, m;
        xin = longint'(x);
        g   = longint'(gain_cfg);
        n   = longint'(norm_cfg);
        m   = longint'(filt_mem[idx]);
        acc = xin * g + m * 4096;
        // round half up, arithmetic shift floors
        y = clamp((acc * n + 134217728) >>> 28, -262144, 262143);
        m = clamp((((xin - y) * g + 2048) >>> 12) + y, -8388608, 8388607);
        filt_mem[idx] = 24'(m);
        return 19'(y);
    endfunction

    // advances the bank state for one sample and returns the held and quantized value
    function automatic result_t hold_and_quantize(input sample_t it);
        result_t            r;
        logic signed [18:0] v;
        longint             held, steps, q, d;
        int                 b;
        r.bank    = it.bank;
        r.channel = it.channel;
        r.held    = '0;
        r.quant   = '0;
        if (int'(it.bank) >= BANKS_N || int'(it.channel) >= CHANNELS_N) begin
            offrange_items++;
            return r;
        end
        b = int'(it.bank);
        if (it.connected) begin
            v = it.sig;
        end else begin
            v = noise_lowpass($signed(it.noise), b * CHANNELS_N + int'(it.channel));
            filtered_items++;
        end
        // schmitt trigger, latch on the rising side only
        if (trig_high[b]) begin
            if ($signed(it.clk_smp) <= CLK_LOW) trig_high[b] = 1'b0;
        end else if ($signed(it.clk_smp) >= CLK_HIGH) begin
            trig_high[b] = 1'b1;
            hold_reg[b]  = v;
            latch_events++;
        end
        held  = longint'(hold_reg[b]);
        steps = clamp(longint'(steps_cfg), longint'(STEPS_MIN), longint'(STEPS_MAX));
        q     = steps * 1024;
        d     = (held - steps * 512) / q;   // truncates toward zero
        r.held  = hold_reg[b];
        r.quant = 19'(d * q);
        return r;
    endfunction

    function automatic int volt_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic [18:0] random_volt();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: return VOLT_MIN;
                1: return VOLT_MAX;
                2: return 19'd0;
                default: return -19'sd1;
            endcase
        end
        return 19'(volt_between(VOLT_LO, VOLT_HI));
    endfunction

    // clock voltages weighted so the triggers keep toggling
    function automatic sample_t random_sample();
        sample_t smp;
        int      pick;
        smp.bank      = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
        // half the items revisit a few channels so filter memories build up
        smp.channel   = ($urandom_range(1) == 0) ? 4'($urandom_range(3)) :
                                                   4'($urandom_range(15));
        smp.connected = 1'($urandom_range(1));
        smp.sig       = random_volt();
        smp.noise     = random_volt();
        pick = int'($urandom_range(19));
        if (pick < 7) begin
            smp.clk_smp = 19'(volt_between(VOLT_LO, int'(CLK_LOW)));
        end else if (pick < 14) begin
            smp.clk_smp = 19'(volt_between(int'(CLK_HIGH), VOLT_HI));
        end else if (pick < 17) begin
            smp.clk_smp = 19'(volt_between(int'(CLK_LOW) + 1, int'(CLK_HIGH) - 1));
        end else begin
            case ($urandom_range(3))
                0: smp.clk_smp = CLK_LOW;
                1: smp.clk_smp = CLK_LOW + 19'sd1;
                2: smp.clk_smp = CLK_HIGH - 19'sd1;
                default: smp.clk_smp = CLK_HIGH;
            endcase
        end
        return smp;
    endfunction

    task automatic compare_field(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // three back-to-back register writes, only called with the block idle
    task automatic load_settings(input logic [3:0] st, input logic [15:0] g,
                                 input logic [15:0] n);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INTERVAL_STEPS;
        cfg_data  <= {12'd0, st};
        @(posedge aclk);
        cfg_index <= CFG_FILTER_GAIN;
        cfg_data  <= g;
        @(posedge aclk);
        cfg_index <= CFG_FILTER_NORM;
        cfg_data  <= n;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // holds the transaction until accepted, then maybe opens a gap
    task automatic offer_sample(input sample_t smp, input logic pin,
                                input logic [18:0] ph, input logic [18:0] pq);
        s_valid         <= 1'b1;
        s_bank          <= smp.bank;
        s_channel       <= smp.channel;
        s_connected     <= smp.connected;
        s_signal_sample <= smp.sig;
        s_noise_sample  <= smp.noise;
        s_clock_sample  <= smp.clk_smp;
        row_pinned      <= pin;
        row_held        <= ph;
        row_quant       <= pq;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (pace_mode != 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 1);
                s_valid <= 1'b0;
                repeat ($urandom_range((pace_mode == 1) ? 8 : 30, 1)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // receiver: ready pattern depends on the stall mode of the phase
    always @(posedge aclk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            m_ready   <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(3) != 0);
                default: begin
                    if ($urandom_range(15) == 0) begin
                        stall_run <= $urandom_range(24, 1);
                        m_ready   <= 1'b0;
                    end else begin
                        m_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // monitor: mirrors register writes, predicts accepted inputs, checks accepted outputs
    always @(posedge aclk) begin
        result_t want;
        sample_t arrived;
        if (!aresetn) begin
            steps_cfg = STEPS_RESET;
            gain_cfg  = GAIN_RESET;
            norm_cfg  = NORM_RESET;
            foreach (filt_mem[i]) filt_mem[i] = '0;
            foreach (trig_high[i]) trig_high[i] = 1'b0;
            foreach (hold_reg[i]) hold_reg[i] = '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_INTERVAL_STEPS: steps_cfg = cfg_data[3:0];
                    CFG_FILTER_GAIN:    gain_cfg  = cfg_data;
                    CFG_FILTER_NORM:    norm_cfg  = cfg_data;
                    default: ;
                endcase
            end
            // output side first; a fresh input can never be answered on its own edge
            if (m_valid && m_ready) begin
                results_seen++;
                if (held_results.size() == 0) begin
                    $display("%0t: result for bank %0d channel %0d with nothing outstanding",
                             $time, m_out_bank, m_out_channel);
                    fail_count++;
                end else begin
                    want = held_results.pop_front();
                    compare_field("out_bank", 32'(want.bank), 32'(m_out_bank));
                    compare_field("out_channel", 32'(want.channel), 32'(m_out_channel));
                    compare_field("held_value", 32'($signed(want.held)), 32'(m_held_value));
                    compare_field("quantized_value", 32'($signed(want.quant)),
                                  32'(m_quantized_value));
                end
            end
            if (s_valid && s_ready) begin
                arrived.bank      = s_bank;
                arrived.channel   = s_channel;
                arrived.connected = s_connected;
                arrived.sig       = s_signal_sample;
                arrived.noise     = s_noise_sample;
                arrived.clk_smp   = s_clock_sample;
                want = hold_and_quantize(arrived);
                // pinned directed rows are checked against their typed values
                if (row_pinned) begin
                    want.held  = row_held;
                    want.quant = row_quant;
                end
                held_results.push_back(want);
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [3:0]  st;
        logic [15:0] gn;
        logic [15:0] nm;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows run with the reset register values
        pace_mode  = 1;
        stall_mode = 1;
        for (int i = 0; i < DIR_ROWS; i++) begin
            offer_sample(opening_rows[i].smp, opening_rows[i].pinned,
                         opening_rows[i].held, opening_rows[i].quant);
        end
        s_valid <= 1'b0;

        // random phases, each under its own register setting and pacing
        for (int p = 0; p < PHASES; p++) begin
            while (results_seen != sent_count) @(posedge aclk);
            if (p < FIXED_PHASES) begin
                st = phase_steps[p];
                gn = phase_gain[p];
                nm = phase_norm[p];
            end else begin
                st = 4'($urandom_range(15));
                gn = 16'($urandom_range(16'hFFFF));
                nm = 16'($urandom_range(16'hFFFF));
            end
            load_settings(st, gn, nm);
            pace_mode  = p % 3;
            stall_mode = (p / 3) % 3;
            burst_left = 0;
            repeat (RAND_PER_PHASE) offer_sample(random_sample(), 1'b0, '0, '0);
            s_valid <= 1'b0;
        end

        // drain, then watch a little longer for stray results
        while (results_seen != sent_count) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d transactions in and %0d out under %0d register settings",
                 sent_count, results_seen, settings_count);
        $display("%0d filtered-noise items, %0d out-of-range items, %0d hold latches",
                 filtered_items, offrange_items, latch_events);
        if (fail_count == 0 && held_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
